// ===== design/blr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blr_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 2;
  localparam int PIX_BITS   = 10;
  localparam int COLOR_BITS = 32;
  localparam int WIDE_BITS  = (COORD_BITS > PIX_BITS) ? COORD_BITS : PIX_BITS;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = 1;
  localparam int Q_CNT_BITS = 2;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ERR_BITS-1:0]   err_t;
  typedef logic [WIDE_BITS-1:0]  wide_t;

  typedef struct packed {
    logic                  operation;
    logic [PIX_BITS-1:0]   x_start;
    logic [PIX_BITS-1:0]   y_start;
    logic [PIX_BITS-1:0]   x_end;
    logic [PIX_BITS-1:0]   y_end;
    logic [COLOR_BITS-1:0] pen_color;
  } cmd_t;

  typedef struct packed {
    logic                  pixel_valid;
    logic [PIX_BITS-1:0]   pixel_x;
    logic [PIX_BITS-1:0]   pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  line_done;
  } pix_t;

  typedef struct packed {
    logic                  is_start;
    coord_t                x0;
    coord_t                y0;
    coord_t                x1;
    coord_t                y1;
    coord_t                dx;
    coord_t                dy;
    err_t                  err;
    logic                  xb;
    logic                  yb;
    logic [COLOR_BITS-1:0] color;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic coord_t to_coord(input logic [PIX_BITS-1:0] v);
    wide_t t;
    t = WIDE_BITS'(v);
    return t[COORD_BITS-1:0];
  endfunction

  function automatic logic [PIX_BITS-1:0] to_pix(input coord_t v);
    wide_t t;
    t = WIDE_BITS'(v);
    return t[PIX_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/blr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blr_front (
  input  wire                   cmd_valid,
  output logic                  cmd_stall,
  input  blr_pkg::cmd_t         cmd,
  input  blr_pkg::q_status_t    q_status,
  output logic                  push,
  output blr_pkg::entry_t       entry
);

  blr_pkg::coord_t x0, y0, x1, y1, dx, dy;
  logic            x_fwd, y_fwd;

  always_comb begin
    x0    = blr_pkg::to_coord(cmd.x_start);
    y0    = blr_pkg::to_coord(cmd.y_start);
    x1    = blr_pkg::to_coord(cmd.x_end);
    y1    = blr_pkg::to_coord(cmd.y_end);
    x_fwd = x0 < x1;
    y_fwd = y0 < y1;
    dx    = x_fwd ? (x1 - x0) : (x0 - x1);
    dy    = y_fwd ? (y1 - y0) : (y0 - y1);

    entry.is_start = (blr_pkg::op_t'(cmd.operation) == blr_pkg::OP_START);
    entry.x0       = x0;
    entry.y0       = y0;
    entry.x1       = x1;
    entry.y1       = y1;
    entry.dx       = dx;
    entry.dy       = dy;
    entry.err      = blr_pkg::ERR_BITS'(dx) - blr_pkg::ERR_BITS'(dy);
    entry.xb       = !x_fwd;
    entry.yb       = !y_fwd;
    entry.color    = cmd.pen_color;
  end

  assign cmd_stall = q_status.full;
  assign push      = cmd_valid && !q_status.full;

endmodule

`default_nettype wire

// ===== design/blr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blr_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  blr_pkg::entry_t       wr_entry,
  input  wire                   pop,
  output blr_pkg::entry_t       rd_entry,
  output blr_pkg::q_status_t    status
);

  blr_pkg::entry_t                  slots [blr_pkg::Q_DEPTH];
  logic [blr_pkg::Q_PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [blr_pkg::Q_CNT_BITS-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  assign rd_entry     = slots[rd_ptr];
  assign status.full  = (count == blr_pkg::Q_CNT_BITS'(blr_pkg::Q_DEPTH));
  assign status.empty = (count == '0);

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty) else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ===== design/blr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blr_back (
  input  wire                   clk,
  input  wire                   rst,
  input  blr_pkg::q_status_t    q_status,
  input  blr_pkg::entry_t       entry,
  output logic                  pop,
  output logic                  pix_valid,
  input  wire                   pix_stall,
  output blr_pkg::pix_t         pix
);

  blr_pkg::coord_t cur_x, cur_y, goal_x, goal_y, delta_x, delta_y;
  blr_pkg::err_t   error_term;
  logic            x_backward, y_backward, drawing;
  logic [blr_pkg::COLOR_BITS-1:0] held_color;

  blr_pkg::coord_t cur_x_next, cur_y_next, goal_x_next, goal_y_next;
  blr_pkg::coord_t delta_x_next, delta_y_next;
  blr_pkg::err_t   error_term_next;
  logic            x_backward_next, y_backward_next, drawing_next;
  logic [blr_pkg::COLOR_BITS-1:0] held_color_next;
  blr_pkg::pix_t   result;

  logic                          last, x_step, y_step;
  logic [blr_pkg::ERR_BITS:0]    e2, neg_dy, dx_w;

  assign pop = !q_status.empty && (!pix_valid || !pix_stall);

  always_comb begin
    if (entry.is_start) begin
      cur_x_next      = entry.x0;
      cur_y_next      = entry.y0;
      goal_x_next     = entry.x1;
      goal_y_next     = entry.y1;
      delta_x_next    = entry.dx;
      delta_y_next    = entry.dy;
      error_term_next = entry.err;
      x_backward_next = entry.xb;
      y_backward_next = entry.yb;
      held_color_next = entry.color;
    end else begin
      cur_x_next      = cur_x;
      cur_y_next      = cur_y;
      goal_x_next     = goal_x;
      goal_y_next     = goal_y;
      delta_x_next    = delta_x;
      delta_y_next    = delta_y;
      error_term_next = error_term;
      x_backward_next = x_backward;
      y_backward_next = y_backward;
      held_color_next = held_color;
    end
    drawing_next = drawing;

    last   = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
    e2     = {error_term_next, 1'b0};
    dx_w   = (blr_pkg::ERR_BITS + 1)'(delta_x_next);
    neg_dy = -((blr_pkg::ERR_BITS + 1)'(delta_y_next));
    x_step = ($signed(e2) >= $signed(neg_dy)) && (cur_x_next != goal_x_next);
    y_step = ($signed(e2) <= $signed(dx_w)) && (cur_y_next != goal_y_next);

    result.pixel_valid = 1'b1;
    result.pixel_x     = blr_pkg::to_pix(cur_x_next);
    result.pixel_y     = blr_pkg::to_pix(cur_y_next);
    result.pixel_color = held_color_next;
    result.line_done   = last;

    if (!entry.is_start && !drawing) begin
      result = '0;
    end else if (last) begin
      drawing_next = 1'b0;
    end else begin
      drawing_next = 1'b1;
      if (x_step) begin
        cur_x_next = x_backward_next ? cur_x_next - 1'b1 : cur_x_next + 1'b1;
      end
      if (y_step) begin
        cur_y_next = y_backward_next ? cur_y_next - 1'b1 : cur_y_next + 1'b1;
      end
      error_term_next = error_term_next
                      - (x_step ? blr_pkg::ERR_BITS'(delta_y_next) : '0)
                      + (y_step ? blr_pkg::ERR_BITS'(delta_x_next) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      goal_x     <= '0;
      goal_y     <= '0;
      delta_x    <= '0;
      delta_y    <= '0;
      error_term <= '0;
      x_backward <= 1'b0;
      y_backward <= 1'b0;
      held_color <= '0;
      drawing    <= 1'b0;
      pix_valid  <= 1'b0;
    end else begin
      if (pop) begin
        cur_x      <= cur_x_next;
        cur_y      <= cur_y_next;
        goal_x     <= goal_x_next;
        goal_y     <= goal_y_next;
        delta_x    <= delta_x_next;
        delta_y    <= delta_y_next;
        error_term <= error_term_next;
        x_backward <= x_backward_next;
        y_backward <= y_backward_next;
        held_color <= held_color_next;
        drawing    <= drawing_next;
        pix_valid  <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) pix <= result;
  end

`ifndef ASSERT_OFF
  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && result.line_done) |=> !drawing)
    else $error("still drawing after the last pixel");
  a_idle_result_empty: assert property (@(posedge clk) disable iff (rst)
    (pop && !result.pixel_valid) |=> (!drawing && pix_valid && pix == '0))
    else $error("idle advance did not give an empty result");
`endif

endmodule

`default_nettype wire

// ===== design/bresenham_line_rasterizer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bresenham line rasterizer. A start transaction (operation 0) latches both end
// points and the pen color and returns the first pixel; each advance transaction
// (operation 1) returns the next pixel, and the end point comes back with
// line_done set. An advance while no line is active returns an all-zero result.
// Every command transaction yields exactly one pixel transaction. The front end
// computes deltas, directions and the initial error in the cycle that accepts a
// command, which is written into a two-entry queue at that edge; the back end runs
// one Bresenham step per cycle while pix_stall is low, so the block sustains one
// transaction per clock when nothing stalls. A command passes through its queue
// entry and then the registered pix output before its pixel is presented.

module bresenham_line_rasterizer (
  input  wire            clk,
  input  wire            rst,
  input  wire            cmd_valid,
  output logic           cmd_stall,
  input  blr_pkg::cmd_t  cmd,
  output logic           pix_valid,
  input  wire            pix_stall,
  output blr_pkg::pix_t  pix
);

  blr_pkg::q_status_t q_status;
  blr_pkg::entry_t    wr_entry, rd_entry;
  logic               push, pop;

  blr_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_status  (q_status),
    .push      (push),
    .entry     (wr_entry)
  );

  blr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .status   (q_status)
  );

  blr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .entry     (rd_entry),
    .pop       (pop),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix)
  );

endmodule

`default_nettype wire
